// ===== sv/tensor_axis_permute_index_top_assert.svh =====
// assertion macros shared by the permute index checker
// no dependencies; include by bare file name
`ifndef TENSOR_AXIS_PERMUTE_INDEX_TOP_ASSERT_SVH
`define TENSOR_AXIS_PERMUTE_INDEX_TOP_ASSERT_SVH

// same-cycle implication on the rising edge of clk
`define TAPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tapi check failed");

// next-cycle implication on the rising edge of clk
`define TAPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tapi check failed");

`endif

// ===== sv/tapi_pkg.sv =====
// shared constants and register codes for the tensor axis permute index block
// no dependencies
package tapi_pkg;

  localparam int IDX_W        = 48;
  localparam int REG_AXES     = 4;
  localparam int DEF_MAX_AXES = 4;
  localparam int DEF_DIM_BITS = 12;
  localparam int APB_AW       = 5;
  localparam int APB_DW       = 32;
  localparam int AXCNT_W      = 3;
  localparam int ORDER_W      = 8;

  localparam logic [AXCNT_W-1:0] RST_AXIS_COUNT = 3'd4;
  localparam logic [ORDER_W-1:0] RST_AXIS_ORDER = 8'd228;

  typedef enum logic [2:0] {
    REG_AXIS_COUNT  = 3'd0,
    REG_AXIS_SIZE_0 = 3'd1,
    REG_AXIS_SIZE_1 = 3'd2,
    REG_AXIS_SIZE_2 = 3'd3,
    REG_AXIS_SIZE_3 = 3'd4,
    REG_AXIS_ORDER  = 3'd5
  } reg_idx_t;

endpackage

// ===== sv/tapi_cfg.sv =====
// register file and stride builder for the permute index block
// depends on tapi_pkg
module tapi_cfg import tapi_pkg::*; #(
  parameter int MAX_AXES = DEF_MAX_AXES,
  parameter int DIM_BITS = DEF_DIM_BITS,
  localparam int NAX   = (MAX_AXES < REG_AXES) ? MAX_AXES : REG_AXES,
  localparam int CNT_W = REG_AXES * DIM_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic                busy,
  output logic [CNT_W-1:0]    elem_count,
  output logic                bad_order,
  output logic [DIM_BITS-1:0] divisor [NAX],
  output logic [IDX_W-1:0]    mstride [NAX]
);

  localparam int K_W   = $clog2(NAX);
  localparam int PRD_W = CNT_W + DIM_BITS;
  localparam int EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic {S_IDLE, S_CALC} state_t;

  logic [AXCNT_W-1:0]  axis_count_r;
  logic [DIM_BITS-1:0] size_r [REG_AXES];
  logic [ORDER_W-1:0]  order_r;
  state_t              state_r;
  logic [K_W-1:0]      k_r;
  logic [CNT_W-1:0]    acc_r;
  logic [CNT_W-1:0]    acc_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    stride_r [REG_AXES];

  logic                wr;
  reg_idx_t            widx;
  logic [AXCNT_W-1:0]  n_use;
  logic [DIM_BITS-1:0] factor;
  logic [PRD_W-1:0]    prod;
  logic [EXT_W-1:0]    acc_ext;

  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[APB_AW-1:2]);
  assign pready = 1'b1;
  assign n_use  = (axis_count_r > AXCNT_W'(NAX)) ? AXCNT_W'(NAX) : axis_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= RST_AXIS_COUNT;
      for (int i = 0; i < REG_AXES; i++) size_r[i] <= DIM_BITS'(1);
      order_r      <= RST_AXIS_ORDER;
    end else if (wr) begin
      unique case (widx)
        REG_AXIS_COUNT:  axis_count_r <= pwdata[AXCNT_W-1:0];
        REG_AXIS_SIZE_0: size_r[0]    <= pwdata[DIM_BITS-1:0];
        REG_AXIS_SIZE_1: size_r[1]    <= pwdata[DIM_BITS-1:0];
        REG_AXIS_SIZE_2: size_r[2]    <= pwdata[DIM_BITS-1:0];
        REG_AXIS_SIZE_3: size_r[3]    <= pwdata[DIM_BITS-1:0];
        REG_AXIS_ORDER:  order_r      <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // axes past the count act as size-1 inner axes
  assign factor  = (AXCNT_W'(k_r) < n_use) ? size_r[2'(k_r)] : DIM_BITS'(1);
  assign prod    = PRD_W'(acc_r) * PRD_W'(factor);
  assign acc_nxt = prod[CNT_W-1:0];
  assign acc_ext = EXT_W'(acc_r);

  // strides are rebuilt innermost first after reset and after every write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CALC;
      k_r     <= K_W'(NAX - 1);
      acc_r   <= CNT_W'(1);
    end else if (wr) begin
      state_r <= S_CALC;
      k_r     <= K_W'(NAX - 1);
      acc_r   <= CNT_W'(1);
    end else begin
      unique case (state_r)
        S_CALC: begin
          stride_r[2'(k_r)] <= acc_ext[IDX_W-1:0];
          acc_r             <= acc_nxt;
          if (k_r == '0) begin
            count_r <= acc_nxt;
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r - K_W'(1);
          end
        end
        S_IDLE: ;
        default: state_r <= S_CALC;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign elem_count = count_r;

  always_comb begin
    logic [1:0] pj;
    logic       use_j;
    bad_order = 1'b0;
    for (int j = 0; j < NAX; j++) begin
      pj    = order_r[2*j +: 2];
      use_j = AXCNT_W'(j) < n_use;
      if (use_j && (AXCNT_W'(pj) >= n_use)) bad_order = 1'b1;
      divisor[j] = use_j ? size_r[pj] : DIM_BITS'(1);
      mstride[j] = use_j ? stride_r[pj] : '0;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (widx)
      REG_AXIS_COUNT:  prdata = APB_DW'(axis_count_r);
      REG_AXIS_SIZE_0: prdata = APB_DW'(size_r[0]);
      REG_AXIS_SIZE_1: prdata = APB_DW'(size_r[1]);
      REG_AXIS_SIZE_2: prdata = APB_DW'(size_r[2]);
      REG_AXIS_SIZE_3: prdata = APB_DW'(size_r[3]);
      REG_AXIS_ORDER:  prdata = APB_DW'(order_r);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== sv/tapi_front.sv =====
// front end: takes an index transfer, flags it and holds it for the back end
// depends on tapi_pkg
module tapi_front import tapi_pkg::*; #(
  parameter int DIM_BITS = DEF_DIM_BITS,
  localparam int CNT_W = REG_AXES * DIM_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [IDX_W-1:0] dest_index,
  input  logic [CNT_W-1:0] elem_count,
  input  logic             bad_order,
  output logic             q_valid,
  output logic [IDX_W-1:0] q_idx,
  output logic             q_oor,
  output logic             q_bad
);

  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic             q_valid_r;
  logic [IDX_W-1:0] q_idx_r;
  logic             q_oor_r;
  logic             q_bad_r;
  logic             accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid_r <= 1'b0;
    else        q_valid_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_idx_r <= dest_index;
      q_oor_r <= CMP_W'(dest_index) >= CMP_W'(elem_count);
      q_bad_r <= bad_order;
    end
  end

  assign q_valid = q_valid_r;
  assign q_idx   = q_idx_r;
  assign q_oor   = q_oor_r;
  assign q_bad   = q_bad_r;

endmodule

// ===== sv/tapi_back.sv =====
// back end: bit-serial divide stages for every output axis but the outermost, then stride multiply-accumulate
// depends on tapi_pkg
module tapi_back import tapi_pkg::*; #(
  parameter int MAX_AXES = DEF_MAX_AXES,
  parameter int DIM_BITS = DEF_DIM_BITS,
  localparam int NAX = (MAX_AXES < REG_AXES) ? MAX_AXES : REG_AXES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [IDX_W-1:0]    in_idx,
  input  logic                in_oor,
  input  logic                in_bad,
  input  logic [DIM_BITS-1:0] divisor [NAX],
  input  logic [IDX_W-1:0]    mstride [NAX],
  output logic                res_valid,
  output logic [IDX_W-1:0]    res_src,
  output logic                res_oor,
  output logic                res_bad
);

  localparam int ND    = NAX - 1;
  localparam int DSTG  = IDX_W + 2;
  localparam int NCH   = (IDX_W + DIM_BITS - 1) / DIM_BITS;
  localparam int NSLOT = ND * DSTG + 2 * NCH;
  localparam int PW    = IDX_W + DIM_BITS;
  localparam int CH_W  = NCH * DIM_BITS;

  typedef struct packed {
    logic                oor;
    logic                bad;
    logic [IDX_W-1:0]    num;
    logic [DIM_BITS-1:0] rem;
    logic [IDX_W-1:0]    acc;
    logic [IDX_W-1:0]    prod;
  } slot_t;

  slot_t            sl_in;
  slot_t            sl_r [NSLOT];
  logic [NSLOT-1:0] vld_r;

  always_comb begin
    sl_in      = '0;
    sl_in.oor  = in_oor;
    sl_in.bad  = in_bad;
    sl_in.num  = in_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[NSLOT-2:0], in_valid};
  end

  for (genvar g = 0; g < NSLOT; g++) begin : g_stg
    slot_t src;
    slot_t nx;

    if (g == 0) begin : g_first
      assign src = sl_in;
    end else begin : g_next
      assign src = sl_r[g-1];
    end

    if (g < ND * DSTG) begin : g_div
      localparam int D = g / DSTG;
      localparam int K = g % DSTG;
      localparam int J = NAX - 1 - D;
      if (K < IDX_W) begin : g_bit
        // one quotient bit per stage, remainder restarts at each axis
        logic [DIM_BITS:0] t;
        logic [DIM_BITS:0] dv;
        logic              ge;
        always_comb begin
          nx  = src;
          dv  = {1'b0, divisor[J]};
          t   = {((K == 0) ? {DIM_BITS{1'b0}} : src.rem), src.num[IDX_W-1]};
          ge  = t >= dv;
          nx.rem = ge ? DIM_BITS'(t - dv) : t[DIM_BITS-1:0];
          nx.num = {src.num[IDX_W-2:0], ge};
        end
      end else if (K == IDX_W) begin : g_mul
        logic [PW-1:0] full;
        always_comb begin
          nx      = src;
          full    = PW'(src.rem) * PW'(mstride[J]);
          nx.prod = full[IDX_W-1:0];
        end
      end else begin : g_add
        always_comb begin
          nx     = src;
          nx.acc = src.acc + src.prod;
        end
      end
    end else begin : g_top
      localparam int C   = (g - ND * DSTG) / 2;
      localparam int ODD = (g - ND * DSTG) % 2;
      if (ODD == 0) begin : g_cmul
        // outermost digit may be wide when order entries repeat
        logic [CH_W-1:0]     ext;
        logic [DIM_BITS-1:0] chunk;
        logic [PW-1:0]       full;
        logic [IDX_W-1:0]    low;
        always_comb begin
          nx      = src;
          ext     = CH_W'(src.num);
          chunk   = ext[C*DIM_BITS +: DIM_BITS];
          full    = PW'(chunk) * PW'(mstride[0]);
          low     = full[IDX_W-1:0];
          nx.prod = low << (C * DIM_BITS);
        end
      end else begin : g_cadd
        always_comb begin
          nx     = src;
          nx.acc = src.acc + src.prod;
        end
      end
    end

    always_ff @(posedge clk) begin
      sl_r[g] <= nx;
    end
  end

  assign res_valid = vld_r[NSLOT-1];
  assign res_oor   = sl_r[NSLOT-1].oor;
  assign res_bad   = sl_r[NSLOT-1].bad;
  assign res_src   = (sl_r[NSLOT-1].oor || sl_r[NSLOT-1].bad) ? '0 : sl_r[NSLOT-1].acc;

endmodule

// ===== sv/tensor_axis_permute_index_top.sv =====
// throughput: one index per cycle while busy is low, set by the
// one-bit-per-stage divide pipeline
// busy is high after reset and after each register write
// while the stride builder walks the axes; results cannot be held off
// reset: synchronous active-low rst_n clears control and loads register defaults
module tensor_axis_permute_index_top import tapi_pkg::*; #(
  parameter int MAX_AXES = DEF_MAX_AXES,
  parameter int DIM_BITS = DEF_DIM_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  in_dest_index,
  output logic              out_strobe,
  output logic [IDX_W-1:0]  out_source_index,
  output logic              out_index_out_of_range,
  output logic              out_order_invalid,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int NAX   = (MAX_AXES < REG_AXES) ? MAX_AXES : REG_AXES;
  localparam int CNT_W = REG_AXES * DIM_BITS;

  logic [CNT_W-1:0]    elem_count;
  logic                bad_order;
  logic [DIM_BITS-1:0] divisor [NAX];
  logic [IDX_W-1:0]    mstride [NAX];
  logic                q_valid;
  logic [IDX_W-1:0]    q_idx;
  logic                q_oor;
  logic                q_bad;

  tapi_cfg #(.MAX_AXES(MAX_AXES), .DIM_BITS(DIM_BITS)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .busy, .elem_count, .bad_order, .divisor, .mstride
  );

  tapi_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk, .rst_n, .start, .busy,
    .dest_index (in_dest_index),
    .elem_count, .bad_order,
    .q_valid, .q_idx, .q_oor, .q_bad
  );

  tapi_back #(.MAX_AXES(MAX_AXES), .DIM_BITS(DIM_BITS)) u_back (
    .clk, .rst_n,
    .in_valid  (q_valid),
    .in_idx    (q_idx),
    .in_oor    (q_oor),
    .in_bad    (q_bad),
    .divisor, .mstride,
    .res_valid (out_strobe),
    .res_src   (out_source_index),
    .res_oor   (out_index_out_of_range),
    .res_bad   (out_order_invalid)
  );

endmodule

// ===== sv/tapi_checker.sv =====
// port-level checks for the permute index top level, bound in below
// depends on tapi_pkg and tensor_axis_permute_index_top_assert.svh
`include "tensor_axis_permute_index_top_assert.svh"

module tapi_checker import tapi_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_strobe,
  input logic [IDX_W-1:0] out_source_index,
  input logic             out_index_out_of_range,
  input logic             out_order_invalid,
  input logic             psel,
  input logic             penable,
  input logic             pwrite
);

  `TAPI_ASSERT_NOW(a_oor_zero, out_strobe && out_index_out_of_range, out_source_index == '0)
  `TAPI_ASSERT_NOW(a_bad_zero, out_strobe && out_order_invalid, out_source_index == '0)
  // a register write always forces a stride rebuild
  `TAPI_ASSERT_NXT(a_wr_busy, psel && penable && pwrite, busy)

endmodule

bind tensor_axis_permute_index_top tapi_checker u_tapi_chk (.*);

// ===== tb/tb_tensor_axis_permute_index_top.sv =====
// testbench for the tensor axis permute index block: programs shapes and orders over apb,
// streams destination indices and checks source indices and flags against a local predictor
// depends on tapi_pkg and tensor_axis_permute_index_top
module tb_tensor_axis_permute_index_top;
  import tapi_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] source_index;
    logic             index_out_of_range;
    logic             order_invalid;
  } permute_result_t;

  class permute_scoreboard;
    logic [AXCNT_W-1:0] axis_count;
    logic [11:0]        axis_size [REG_AXES];
    logic [ORDER_W-1:0] axis_order;
    permute_result_t    pending_q[$];
    int                 error_count;

    function new();
      axis_count = RST_AXIS_COUNT;
      foreach (axis_size[i]) axis_size[i] = 12'd1;
      axis_order  = RST_AXIS_ORDER;
      error_count = 0;
    endfunction

    function void write_reg(reg_idx_t r, logic [31:0] value);
      case (r)
        REG_AXIS_COUNT:  axis_count = value[AXCNT_W-1:0];
        REG_AXIS_SIZE_0: axis_size[0] = value[11:0];
        REG_AXIS_SIZE_1: axis_size[1] = value[11:0];
        REG_AXIS_SIZE_2: axis_size[2] = value[11:0];
        REG_AXIS_SIZE_3: axis_size[3] = value[11:0];
        REG_AXIS_ORDER:  axis_order = value[ORDER_W-1:0];
        default: ;
      endcase
    endfunction

    function int axes_used();
      return (axis_count > REG_AXES) ? REG_AXES : int'(axis_count);
    endfunction

    function longint unsigned elem_count();
      longint unsigned c;
      c = 1;
      for (int j = 0; j < axes_used(); j++) c = c * axis_size[j];
      return c;
    endfunction

    function permute_result_t permute_source(logic [IDX_W-1:0] dest);
      permute_result_t res;
      int n;
      int perm [REG_AXES];
      longint unsigned src_stride [REG_AXES];
      longint unsigned dst_stride [REG_AXES];
      longint unsigned idx, src, s, d;
      n = axes_used();
      idx = 64'(dest);
      src = 0;
      res.order_invalid = 1'b0;
      for (int j = 0; j < n; j++) begin
        perm[j] = (axis_order >> (2 * j)) & 3;
        if (perm[j] >= n) res.order_invalid = 1'b1;
      end
      res.index_out_of_range = (idx >= elem_count());
      if (!res.order_invalid && !res.index_out_of_range) begin
        s = 1;
        d = 1;
        for (int j = n - 1; j >= 0; j--) begin
          src_stride[j] = s;
          s = s * axis_size[j];
          dst_stride[j] = d;
          d = d * axis_size[perm[j]];
        end
        for (int j = 0; j < n; j++) begin
          if (dst_stride[j] == 0) break;
          src = src + (idx / dst_stride[j]) * src_stride[perm[j]];
          idx = idx % dst_stride[j];
        end
      end
      res.source_index = (res.order_invalid || res.index_out_of_range) ? '0 : src[IDX_W-1:0];
      return res;
    endfunction

    function void note_input(logic [IDX_W-1:0] dest);
      pending_q.push_back(permute_source(dest));
    endfunction

    function void check_result(permute_result_t got);
      permute_result_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual src=%h oor=%b inv=%b",
                 $time, got.source_index, got.index_out_of_range, got.order_invalid);
        error_count++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.source_index !== exp_r.source_index) begin
        $display("%0t: source_index mismatch, expected %h, actual %h",
                 $time, exp_r.source_index, got.source_index);
        error_count++;
      end
      if (got.index_out_of_range !== exp_r.index_out_of_range) begin
        $display("%0t: index_out_of_range mismatch, expected %b, actual %b",
                 $time, exp_r.index_out_of_range, got.index_out_of_range);
        error_count++;
      end
      if (got.order_invalid !== exp_r.order_invalid) begin
        $display("%0t: order_invalid mismatch, expected %b, actual %b",
                 $time, exp_r.order_invalid, got.order_invalid);
        error_count++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [IDX_W-1:0]  in_dest_index = '0;
  logic              out_strobe;
  logic [IDX_W-1:0]  out_source_index;
  logic              out_index_out_of_range;
  logic              out_order_invalid;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  permute_scoreboard sb = new();
  int                burst_left = 0;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  tensor_axis_permute_index_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    permute_result_t got;
    if (rst_n && out_strobe) begin
      got.source_index       = out_source_index;
      got.index_out_of_range = out_index_out_of_range;
      got.order_invalid      = out_order_invalid;
      sb.check_result(got);
    end
  end

  task automatic apb_write(reg_idx_t r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus returns to idle before the next transfer
    @(posedge clk);
    sb.write_reg(r, value);
  endtask

  // hold start until a transfer completes; bursts separated by random gaps
  task automatic send_index(logic [IDX_W-1:0] dest);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    start         <= 1'b1;
    in_dest_index <= dest;
    do @(posedge clk); while (busy);
    sb.note_input(dest);
    burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic program_shape(int cnt, int s0, int s1, int s2, int s3, int ord);
    drain();
    apb_write(REG_AXIS_COUNT, cnt);
    apb_write(REG_AXIS_SIZE_0, s0);
    apb_write(REG_AXIS_SIZE_1, s1);
    apb_write(REG_AXIS_SIZE_2, s2);
    apb_write(REG_AXIS_SIZE_3, s3);
    apb_write(REG_AXIS_ORDER, ord);
  endtask

  function automatic int rand_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    if (r < 4) return $urandom_range(1, 4095);
    return $urandom_range(1, 12);
  endfunction

  // valid permutation of the axes in use, with random upper entries
  function automatic int rand_order(int n);
    int p [4];
    int k, t, ord;
    for (int i = 0; i < 4; i++) p[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = p[i];
      p[i] = p[k];
      p[k] = t;
    end
    ord = $urandom_range(0, 255);
    for (int i = 0; i < n && i < 4; i++) ord = (ord & ~(3 << (2 * i))) | (p[i] << (2 * i));
    return ord;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    longint unsigned c, r;
    c = sb.elem_count();
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return r[IDX_W-1:0];
      1: return (c == 0) ? '0 : IDX_W'(c - 1);
      2: return IDX_W'(c);
      default: return (c == 0) ? r[IDX_W-1:0] : IDX_W'(r % c);
    endcase
  endfunction

  initial begin
    int cnt, ord;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape: one element
    send_index('0);
    send_index(48'd1);
    send_index(IDX_MAX);
    // largest shape, reversed axes
    program_shape(4, 4095, 4095, 4095, 4095, 8'h1B);
    send_index('0);
    send_index(IDX_W'(sb.elem_count() - 1));
    send_index(IDX_W'(sb.elem_count()));
    send_index(IDX_MAX);
    send_index(48'h5555_5555_5555);
    // no axes in use
    program_shape(0, 3, 3, 3, 3, 8'hFF);
    send_index('0);
    send_index(48'd1);
    // axis count saturates above four
    program_shape(7, 2, 3, 4, 5, 8'h4E);
    for (int i = 0; i < 4; i++) send_index(IDX_W'($urandom_range(0, 119)));
    // zero size: everything out of range
    program_shape(2, 0, 5, 1, 1, 8'h01);
    send_index('0);
    send_index(48'd3);
    // bad order entry, alone and with out of range
    program_shape(2, 3, 4, 1, 1, 8'h0C);
    send_index(48'd5);
    send_index(48'd12);
    // repeated order entries
    program_shape(3, 5, 6, 7, 1, 8'h00);
    for (int i = 0; i < 4; i++) send_index(IDX_W'($urandom_range(0, 209)));
    program_shape(1, 4095, 1, 1, 1, 8'hFC);
    send_index(48'd4094);
    send_index(48'd4095);

    for (int ph = 0; ph < 18; ph++) begin
      cnt = (ph % 6 == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      ord = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                         : rand_order(cnt > 4 ? 4 : cnt);
      program_shape(cnt, rand_size(), rand_size(), rand_size(), rand_size(), ord);
      for (int i = 0; i < 34; i++) send_index(rand_index());
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tapi_pkg.sv
sv/tapi_cfg.sv
sv/tapi_front.sv
sv/tapi_back.sv
sv/tensor_axis_permute_index_top.sv
sv/tapi_checker.sv
tb/tb_tensor_axis_permute_index_top.sv
